// ===== rtl/spm_pkg.sv =====
package spm_pkg;

	// Pixel and coefficient geometry.
	localparam int PIXEL_BITS = 12;
	localparam int COEF_W     = 32;
	localparam int CFG_W      = 64;
	localparam int IDX_W      = 3;
	localparam int OUT_W      = 16;

	// A coefficient times a zero-extended pixel, and the row sum of two of them plus an offset.
	localparam int PROD_W  = COEF_W + PIXEL_BITS + 1;
	localparam int SUM_W   = PROD_W + 1;
	localparam int MAG_W   = SUM_W;
	localparam int QUO_W   = OUT_W;
	localparam int WIDE_W  = MAG_W + QUO_W;
	localparam int DIV_STEPS = QUO_W;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_ROW0_LIN = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW0_OFF = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROW1_LIN = 3'd2;
	localparam logic [IDX_W-1:0] REG_ROW1_OFF = 3'd3;
	localparam logic [IDX_W-1:0] REG_ROW2_LIN = 3'd4;
	localparam logic [IDX_W-1:0] REG_ROW2_OFF = 3'd5;

	// One in Q12.20.
	localparam logic [COEF_W-1:0] COEF_ONE = 32'h0010_0000;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = -16'sh8000;

	// State of one quotient while it moves through the divider stages.
	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             sat;
		logic             nz;
	} field_t;

endpackage

// ===== rtl/stereo_pixel_point_mapping.sv =====
// Pipeline from an accepted request to its result: multiply, row sum, magnitude and range
// check stages, then 16 restoring divide steps of one bit each, then the output register.
// Throughput: one pixel per cycle; the whole pipeline advances whenever the output
// register is empty or its result is taken, so a stall holds every stage in place.
// Reset: asynchronous, active low; clears all stage valid bits and loads the matrix with
// all coefficients zero except h22, which is one.
module stereo_pixel_point_mapping
	import spm_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [IDX_W-1:0]             cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [PIXEL_BITS-1:0]        pixel_x,
	input  logic [PIXEL_BITS-1:0]        pixel_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [OUT_W-1:0]      mapped_x,
	output logic signed [OUT_W-1:0]      mapped_y,
	output logic                         valid_res
);

	// Matrix coefficients, row major: h00 h01 h02 h10 h11 h12 h20 h21 h22.
	logic signed [COEF_W-1:0] coef_q [9];

	logic adv;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [PROD_W-1:0] prod_s1 [6];
	logic signed [SUM_W-1:0]  nu_s2, nv_s2, w_s2;
	logic [MAG_W-1:0]         mu_s3, mv_s3, mw_s3;
	logic                     su_s3, sv_s3, sw_s3;
	field_t                   fu_s4, fv_s4;
	logic [MAG_W-1:0]         den_s4;
	logic                     dz_s4;

	// Divider stages; entry 0 is the range-check stage.
	logic                     vld_sd [DIV_STEPS+1];
	field_t                   fu_sd  [DIV_STEPS+1];
	field_t                   fv_sd  [DIV_STEPS+1];
	logic [MAG_W-1:0]         den_sd [DIV_STEPS+1];
	logic                     dz_sd  [DIV_STEPS+1];
	field_t                   fu_nx  [DIV_STEPS];
	field_t                   fv_nx  [DIV_STEPS];

	logic signed [OUT_W-1:0]  res_u, res_v;
	logic                     ok_u, ok_v;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) coef_q[i] <= '0;
			coef_q[8] <= COEF_ONE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ROW0_LIN: begin
					coef_q[0] <= cfg_data[CFG_W-1:COEF_W];
					coef_q[1] <= cfg_data[COEF_W-1:0];
				end
				REG_ROW0_OFF: coef_q[2] <= cfg_data[COEF_W-1:0];
				REG_ROW1_LIN: begin
					coef_q[3] <= cfg_data[CFG_W-1:COEF_W];
					coef_q[4] <= cfg_data[COEF_W-1:0];
				end
				REG_ROW1_OFF: coef_q[5] <= cfg_data[COEF_W-1:0];
				REG_ROW2_LIN: begin
					coef_q[6] <= cfg_data[CFG_W-1:COEF_W];
					coef_q[7] <= cfg_data[COEF_W-1:0];
				end
				REG_ROW2_OFF: coef_q[8] <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves as one whenever the output register can take a new result.
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	assign vld_sd[0] = vld_s4;
	assign fu_sd[0]  = fu_s4;
	assign fv_sd[0]  = fv_s4;
	assign den_sd[0] = den_s4;
	assign dz_sd[0]  = dz_s4;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			out_valid <= vld_sd[DIV_STEPS];
		end
	end

	// Front stages: products, row sums, magnitudes and the range check.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1[0] <= coef_q[0] * $signed({1'b0, pixel_x});
			prod_s1[1] <= coef_q[1] * $signed({1'b0, pixel_y});
			prod_s1[2] <= coef_q[3] * $signed({1'b0, pixel_x});
			prod_s1[3] <= coef_q[4] * $signed({1'b0, pixel_y});
			prod_s1[4] <= coef_q[6] * $signed({1'b0, pixel_x});
			prod_s1[5] <= coef_q[7] * $signed({1'b0, pixel_y});

			nu_s2 <= SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1]) + SUM_W'(coef_q[2]);
			nv_s2 <= SUM_W'(prod_s1[2]) + SUM_W'(prod_s1[3]) + SUM_W'(coef_q[5]);
			w_s2  <= SUM_W'(prod_s1[4]) + SUM_W'(prod_s1[5]) + SUM_W'(coef_q[8]);

			su_s3 <= nu_s2[SUM_W-1];
			sv_s3 <= nv_s2[SUM_W-1];
			sw_s3 <= w_s2[SUM_W-1];
			mu_s3 <= nu_s2[SUM_W-1] ? MAG_W'(-nu_s2) : MAG_W'(nu_s2);
			mv_s3 <= nv_s2[SUM_W-1] ? MAG_W'(-nv_s2) : MAG_W'(nv_s2);
			mw_s3 <= w_s2[SUM_W-1]  ? MAG_W'(-w_s2)  : MAG_W'(w_s2);

			// A quotient of 65536 or more can never fit; the steps then only carry the flag.
			den_s4    <= mw_s3;
			dz_s4     <= (mw_s3 == '0);
			fu_s4.rem <= mu_s3;
			fu_s4.quo <= '0;
			fu_s4.neg <= su_s3 ^ sw_s3;
			fu_s4.nz  <= (mu_s3 != '0);
			fu_s4.sat <= (mw_s3 == '0) || ({{QUO_W{1'b0}}, mu_s3} >= {mw_s3, {QUO_W{1'b0}}});
			fv_s4.rem <= mv_s3;
			fv_s4.quo <= '0;
			fv_s4.neg <= sv_s3 ^ sw_s3;
			fv_s4.nz  <= (mv_s3 != '0);
			fv_s4.sat <= (mw_s3 == '0) || ({{QUO_W{1'b0}}, mv_s3} >= {mw_s3, {QUO_W{1'b0}}});
		end
	end

	// Restoring division, one quotient bit per stage, most significant first.
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int B = DIV_STEPS - 1 - k;
		logic [WIDE_W-1:0] dsh;
		logic [WIDE_W-1:0] rext_u, rext_v;

		assign dsh    = WIDE_W'(den_sd[k]) << B;
		assign rext_u = WIDE_W'(fu_sd[k].rem);
		assign rext_v = WIDE_W'(fv_sd[k].rem);

		always_comb begin
			fu_nx[k] = fu_sd[k];
			if (!fu_sd[k].sat && rext_u >= dsh) begin
				fu_nx[k].rem    = MAG_W'(rext_u - dsh);
				fu_nx[k].quo[B] = 1'b1;
			end
			fv_nx[k] = fv_sd[k];
			if (!fv_sd[k].sat && rext_v >= dsh) begin
				fv_nx[k].rem    = MAG_W'(rext_v - dsh);
				fv_nx[k].quo[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k+1] <= 1'b0;
			end else if (adv) begin
				vld_sd[k+1] <= vld_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				fu_sd[k+1]  <= fu_nx[k];
				fv_sd[k+1]  <= fv_nx[k];
				den_sd[k+1] <= den_sd[k];
				dz_sd[k+1]  <= dz_sd[k];
			end
		end
	end

	// Apply sign and saturate one quotient.
	function automatic logic [OUT_W:0] finish(input field_t f);
		logic [OUT_W:0] r;
		r = {1'b1, f.quo};
		if (!f.nz) begin
			r = {!f.sat || f.quo != '0, {OUT_W{1'b0}}};
			r[OUT_W] = !f.sat;
		end else if (f.sat) begin
			r = {1'b0, f.neg ? OUT_MIN : OUT_MAX};
		end else if (f.neg) begin
			if (f.quo > QUO_W'(17'd32768)) r = {1'b0, OUT_MIN};
			else                           r = {1'b1, QUO_W'(-f.quo)};
		end else if (f.quo[QUO_W-1]) begin
			r = {1'b0, OUT_MAX};
		end
		return r;
	endfunction

	assign {ok_u, res_u} = finish(fu_sd[DIV_STEPS]);
	assign {ok_v, res_v} = finish(fv_sd[DIV_STEPS]);

	// Output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			mapped_x  <= res_u;
			mapped_y  <= res_v;
			valid_res <= ok_u && ok_v;
		end
	end

`ifndef NO_ASSERTIONS
	// A zero denominator never reports a valid mapping.
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sd[DIV_STEPS] && adv && dz_sd[DIV_STEPS]) |=> !valid_res)
		else $error("zero denominator reported as valid");

	// A result held by a stall is not dropped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result lost");

	// The range check leaves a remainder below the divisor shifted by the quotient width.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !fu_s4.sat) |->
		({{QUO_W{1'b0}}, fu_s4.rem} < {den_s4, {QUO_W{1'b0}}}))
		else $error("range check inconsistent");

	// After the last step the remainder of the y quotient is below the divisor.
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sd[DIV_STEPS] && !fv_sd[DIV_STEPS].sat) |->
		(fv_sd[DIV_STEPS].rem < den_sd[DIV_STEPS]))
		else $error("divider remainder too large");
`endif

endmodule
